[hdl/scpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types and constants for the serializer clock pattern calculator.
// ----------------------------------------------------------------------------
package scpc_pkg;

  localparam int SER_BITS_DEF = 8;

  // field widths of the item formats
  localparam int HI_W   = 48;
  localparam int PH_W   = 64;
  localparam int FRAC_W = 32;
  localparam int INT_W  = 17;
  localparam int HIGH_W = 16;
  localparam int PAT_W  = 16;
  localparam int PIW    = $clog2(PAT_W);

  localparam int IN_W  = 2 * HI_W + PH_W;
  localparam int OUT_F = INT_W + HIGH_W + FRAC_W + PH_W + 2 * PAT_W;
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DIV,
    ST_WAIT,
    ST_MARK,
    ST_DONE
  } state_t;

endpackage

[hdl/scpc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_div
// Restoring divider, one quotient bit per cycle. The caller keeps the
// numerator below den * 2^QUO_W.
// ----------------------------------------------------------------------------
module scpc_div #(
  parameter int NUM_W = 7,
  parameter int DEN_W = 4,
  parameter int QUO_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int RW    = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [RW-1:0]    rem;
  logic [RW-1:0]    dsh;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RW'(num);
      dsh <= RW'(den) << (QUO_W - 1);
      quo <= '0;
      cnt <= CNT_W'(QUO_W - 1);
    end else if (busy) begin
      // subtract when the shifted divisor fits, then move one bit down
      if (ge) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

[hdl/serdes_clock_pattern_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serdes_clock_pattern_calc
// Widened period, fraction and serializer edge patterns from high/low times.
// ----------------------------------------------------------------------------
// F = repeat count (1..SER_BITS), found by a search that adds the period once a cycle;
//   each edge offset is one Q-bit divider pass, Q = $clog2(2*SER_BITS).
// Input is taken only in idle, never while an item is in work; the next
//   item may enter while the result waits in the output register.
// Reset: synchronous; returns to idle with the output register empty.
module serdes_clock_pattern_calc
  import scpc_pkg::*;
#(
  parameter int SER_BITS = SER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // hi_time[47:0], lo_time[95:48], phase[159:96]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // wide_int[16:0], high_int[32:17], wide_frac[64:33],
  // phase_copy[128:65], pattern_normal[144:129], pattern_skip[160:145], zeros
  output logic [OUT_W-1:0] m_tdata,
  // invalid[0]
  output logic [0:0]       m_tuser
);

  localparam int FW    = $clog2(SER_BITS + 1);
  localparam int CW    = $clog2(2 * SER_BITS);
  localparam int NW    = $clog2(2 * SER_BITS * SER_BITS);
  localparam int ACC_W = HI_W + 1;
  localparam logic [ACC_W-1:0] TARGET = ACC_W'(SER_BITS) << FRAC_W;

  state_t state, state_next;

  logic [ACC_W-1:0]  period;
  logic [ACC_W-1:0]  acc;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     idx;
  logic [NW-1:0]     num;
  logic [PAT_W-1:0]  normal;
  logic              inv;
  logic [HIGH_W-1:0] hi_int;
  logic [PH_W-1:0]   phase_r;

  logic [HI_W-1:0]   hi_in;
  logic [HI_W-1:0]   lo_in;
  logic [ACC_W-1:0]  sum_in;
  logic              sum_low;
  logic [INT_W-1:0]  cut;
  logic [CW-1:0]     cut_small;
  logic              fill_hit;
  logic              last;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [CW-1:0]     div_quo;

  logic              fut_ok;
  logic [PIW-1:0]    fut_idx;
  logic [INT_W:0]    diff;
  logic              past_ok;
  logic [PIW-1:0]    past_idx;
  logic [PAT_W-1:0]  mark;
  logic [PAT_W-1:0]  below_cut;
  logic [PAT_W-1:0]  skip;
  logic              load_out;

  logic [INT_W-1:0]  o_int;
  logic [HIGH_W-1:0] o_high;
  logic [FRAC_W-1:0] o_frac;
  logic [PH_W-1:0]   o_phase;
  logic [PAT_W-1:0]  o_normal;
  logic [PAT_W-1:0]  o_skip;
  logic              o_inv;

  assign hi_in   = s_tdata[HI_W-1:0];
  assign lo_in   = s_tdata[2*HI_W-1:HI_W];
  assign sum_in  = ACC_W'(hi_in) + ACC_W'(lo_in);
  assign sum_low = (sum_in[ACC_W-1:FRAC_W] == '0);

  assign cut       = acc[FRAC_W +: INT_W];
  assign cut_small = acc[FRAC_W +: CW];
  assign fill_hit  = (acc >= TARGET);
  assign last      = (idx == FW'(fill - FW'(1)));

  // future edge below the serializer word, past edge one cut further up
  assign fut_ok   = (div_quo <= CW'(SER_BITS - 1));
  assign fut_idx  = PIW'(SER_BITS - 1) - PIW'(div_quo);
  assign diff     = {1'b0, cut} - (INT_W + 1)'(div_quo);
  assign past_ok  = !diff[INT_W] && (diff[INT_W-1:0] <= INT_W'(SER_BITS));
  assign past_idx = PIW'(SER_BITS - 1) + diff[PIW-1:0];

  always_comb begin
    mark = normal;
    if (fut_ok) begin
      mark = mark | (PAT_W'(1) << fut_idx);
    end
    if (past_ok) begin
      mark = mark | (PAT_W'(1) << past_idx);
    end
  end

  // drop one bit below the cut position
  always_comb begin
    if (cut >= INT_W'(PAT_W)) begin
      below_cut = '1;
    end else begin
      below_cut = (PAT_W'(1) << cut[PIW-1:0]) - PAT_W'(1);
    end
    skip = (normal & ~below_cut) | ((normal & below_cut) >> 1);
  end

  scpc_div #(
    .NUM_W (NW),
    .DEN_W (FW),
    .QUO_W (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (fill),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sum_low ? ST_DONE : ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_hit) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: state_next = last ? ST_DONE : ST_DIV;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = (state == ST_DIV);
    load_out  = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          period  <= sum_in;
          acc     <= sum_in;
          fill    <= FW'(1);
          idx     <= '0;
          normal  <= '0;
          inv     <= sum_low;
          hi_int  <= hi_in[HI_W-1:FRAC_W];
          phase_r <= s_tdata[IN_W-1:2*HI_W];
        end
      end
      ST_FILL: begin
        if (fill_hit) begin
          num <= NW'(fill - FW'(1));
        end else begin
          acc  <= acc + period;
          fill <= fill + FW'(1);
        end
      end
      ST_MARK: begin
        // advance to the next edge: numerator grows by the low CW bits of the cut
        normal <= mark;
        idx    <= idx + FW'(1);
        num    <= num + NW'(cut_small);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_inv <= inv;
      if (inv) begin
        o_int    <= '0;
        o_high   <= '0;
        o_frac   <= '0;
        o_phase  <= '0;
        o_normal <= '0;
        o_skip   <= '0;
      end else begin
        o_int    <= cut;
        o_high   <= hi_int;
        o_frac   <= acc[FRAC_W-1:0];
        o_phase  <= phase_r;
        o_normal <= normal;
        o_skip   <= skip;
      end
    end
  end

  assign m_tdata = {(OUT_W - OUT_F)'(0), o_skip, o_normal, o_phase, o_frac, o_high, o_int};
  assign m_tuser = o_inv;

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (fill != '0) && (fill <= FW'(SER_BITS)))
    else $error("repeat count out of range");

  a_off_cut: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK) |-> (INT_W'(div_quo) <= cut))
    else $error("edge offset beyond cut position");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("result not presented after load");

endmodule
